FILE: hdl/region_access_attribute_check_macros.svh
// assertion macros for the region access attribute checker
`ifndef REGION_ACCESS_ATTRIBUTE_CHECK_MACROS_SVH
`define REGION_ACCESS_ATTRIBUTE_CHECK_MACROS_SVH

// same-cycle implication, disabled during reset
`define RAAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region check assertion failed");

// next-cycle implication, disabled during reset
`define RAAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region check assertion failed");

`endif

FILE: hdl/raac_pkg.sv
// shared types, codes and helpers of the region access attribute checker
package raac_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 64;
    localparam int ADDR_W = 64;
    localparam int FLAG_W = 3;
    localparam int STATUS_W = 3;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABORTED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INCONSISTENT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd5;

    // one stored region, end precomputed at append time
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic              end_ovf;
        logic [FLAG_W-1:0] flags;     // bit0 exec, bit1 write, bit2 read
    } region_entry_t;

    typedef struct packed {
        logic          en;
        region_entry_t entry;
    } mem_wr_t;

    // permission flags to no-execute / read-only / read-protect
    function automatic logic [FLAG_W-1:0] flags_to_attr(input logic [FLAG_W-1:0] f);
        return ~f;
    endfunction

endpackage

FILE: hdl/raac_req_if.sv
// request channel: one operation per transfer
interface raac_req_if;
    import raac_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic              is_executable;
    logic              is_writable;
    logic              is_readable;

    modport source (output valid, operation, address, length, is_executable,
                    is_writable, is_readable, input ready);
    modport sink (input valid, operation, address, length, is_executable,
                  is_writable, is_readable, output ready);
endinterface

FILE: hdl/raac_rsp_if.sv
// response channel: one status per transfer
interface raac_rsp_if;
    import raac_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FLAG_W-1:0]   attributes;

    modport source (output valid, status, attributes, input ready);
    modport sink (input valid, status, attributes, output ready);
endinterface

FILE: hdl/raac_region_mem.sv
// region table memory, one write port and one registered read port
module raac_region_mem #(
    parameter int DEPTH = raac_pkg::DEFAULT_MAX_ENTRIES,
    parameter int IDX_W = 6
) (
    input  logic                  clk,
    input  raac_pkg::mem_wr_t     wr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output raac_pkg::region_entry_t rd_data
);
    import raac_pkg::*;

    region_entry_t mem [DEPTH];
    region_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: hdl/raac_ctrl.sv
// operation decode, table count, query scan sequencer and result register
module raac_ctrl #(
    parameter int MAX_ENTRIES = raac_pkg::DEFAULT_MAX_ENTRIES,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    raac_req_if.sink                request,
    raac_rsp_if.source              response,
    output raac_pkg::mem_wr_t       wr,
    output logic [IDX_W-1:0]        wr_addr,
    output logic                    rd_en,
    output logic [IDX_W-1:0]        rd_addr,
    input  raac_pkg::region_entry_t rd_data
);
    import raac_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]   qaddr_reg, qaddr_next;
    logic [ADDR_W-1:0]   qend_reg, qend_next;
    logic                found_reg, found_next;
    logic [FLAG_W-1:0]   first_reg, first_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FLAG_W-1:0]   res_attr_reg, res_attr_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FLAG_W-1:0]   out_attr_reg, out_attr_next;

    logic                xfer;
    logic                slot_free;
    logic                table_full;
    logic [ADDR_W-1:0]   len_m1;
    logic [ADDR_W:0]     end_sum;
    logic                query_bad;
    logic                overlap;
    logic [FLAG_W-1:0]   entry_attr;
    logic                scan_found;
    logic [FLAG_W-1:0]   scan_first;
    logic                scan_last;
    logic                scan_stop;

    assign slot_free = !out_valid_reg || response.ready;
    assign request.ready = (state_reg == S_IDLE) &&
                           (slot_free || request.operation == OP_QUERY);
    assign xfer = request.valid && request.ready;

    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));

    // inclusive end of the request range, carry marks overflow
    assign len_m1  = request.length - ADDR_W'(1);
    assign end_sum = {1'b0, request.address} + {1'b0, len_m1};
    assign query_bad = (count_reg == '0) || (request.length == '0) || end_sum[ADDR_W];

    // append write port
    always_comb
    begin
        wr.en               = xfer && (request.operation == OP_APPEND) && !table_full;
        wr.entry.start_addr = request.address;
        wr.entry.end_addr   = end_sum[ADDR_W-1:0];
        wr.entry.end_ovf    = end_sum[ADDR_W];
        wr.entry.flags      = {request.is_readable, request.is_writable,
                               request.is_executable};
    end
    assign wr_addr = count_reg[IDX_W-1:0];

    // scan evaluation of the entry read last cycle
    assign overlap = (qend_reg >= qaddr_reg) &&
                     (((qaddr_reg <= rd_data.start_addr) && (qend_reg >= rd_data.start_addr)) ||
                      ((rd_data.start_addr <= qaddr_reg) && (rd_data.end_addr >= qaddr_reg)));
    assign entry_attr = flags_to_attr(rd_data.flags);
    assign scan_found = found_reg || overlap;
    assign scan_first = (overlap && !found_reg) ? entry_attr : first_reg;
    assign scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign scan_stop  = (rd_data.end_addr >= qend_reg) || scan_last;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        qaddr_next      = qaddr_reg;
        qend_next       = qend_reg;
        found_next      = found_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_attr_next   = res_attr_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_status_next = out_status_reg;
        out_attr_next   = out_attr_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (xfer)
                begin
                    unique case (request.operation)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OK;
                            out_attr_next   = '0;
                        end
                        OP_APPEND:
                        begin
                            if (!table_full)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            out_valid_next  = 1'b1;
                            out_status_next = table_full ? ST_TABLE_FULL : ST_OK;
                            out_attr_next   = '0;
                        end
                        OP_QUERY:
                        begin
                            res_attr_next = '0;
                            if (query_bad)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = '0;
                                qaddr_next = request.address;
                                qend_next  = end_sum[ADDR_W-1:0];
                                found_next = 1'b0;
                                first_next = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_INVALID;
                            out_attr_next   = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                found_next = scan_found;
                first_next = scan_first;
                if (overlap)
                begin
                    qaddr_next = rd_data.end_addr + ADDR_W'(1);
                end
                priority if (rd_data.end_ovf)
                begin
                    res_status_next = ST_ABORTED;
                    state_next      = S_DONE;
                end
                else if (overlap && found_reg && (entry_attr != first_reg))
                begin
                    res_status_next = ST_INCONSISTENT;
                    state_next      = S_DONE;
                end
                else if (scan_stop)
                begin
                    res_status_next = scan_found ? ST_OK : ST_NOT_FOUND;
                    res_attr_next   = scan_found ? scan_first : '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_attr_next   = res_attr_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        qaddr_reg      <= qaddr_next;
        qend_reg       <= qend_next;
        found_reg      <= found_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_attr_reg   <= res_attr_next;
        out_status_reg <= out_status_next;
        out_attr_reg   <= out_attr_next;
    end

    assign response.valid      = out_valid_reg;
    assign response.status     = out_status_reg;
    assign response.attributes = out_attr_reg;
endmodule

FILE: hdl/region_access_attribute_check.sv
// region access attribute checker: an address-ordered region table with a consistency query.
// Clear and append load the response register directly from the transfer on request, and the
// next request is taken as soon as that response is taken or in the same cycle it is. A query
// scans the table one entry per cycle through the single read port of the region memory, with
// the read for the next entry issued while the current one is evaluated, and visits at most
// MAX_ENTRIES entries. A query that is rejected up front (empty table, zero length or a range
// end past the top of the address space) goes straight to its result without a scan. A query
// may be accepted while an earlier response still waits on the response channel; its result
// is held until the response register frees up. Entry ends (start + length - 1, with overflow)
// are worked out when the entry is appended, so the scan itself only compares. The table needs
// no clearing pass: entries at or above the count are never read.
module region_access_attribute_check #(
    parameter int MAX_ENTRIES = raac_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    raac_req_if.sink   request,
    raac_rsp_if.source response
);
    import raac_pkg::*;

    // index width covers the table depth, count width also holds the depth itself
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // append port into the table
    mem_wr_t          wr;
    logic [IDX_W-1:0] wr_addr;

    // scan read port, data arrives in the cycle after the read
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    region_entry_t    rd_data;

    // sequencer: decode, count, scan and response register
    raac_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // region table storage
    raac_region_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );
endmodule

FILE: hdl/raac_checker.sv
// port-level checks of the region access attribute checker and their bind
`include "region_access_attribute_check_macros.svh"

module raac_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [1:0]                    req_operation,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [raac_pkg::STATUS_W-1:0] rsp_status,
    input logic [raac_pkg::FLAG_W-1:0]   rsp_attributes
);
    import raac_pkg::*;

    logic req_xfer;
    assign req_xfer = req_valid && req_ready;

    // a pending response stays until taken
    `RAAC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // a clear answers ok in the next cycle
    `RAAC_ASSERT_NEXT(a_clear_ok, clk, rst_n, req_xfer && req_operation == OP_CLEAR,
                      rsp_valid && rsp_status == ST_OK)
    // an append answers ok or full in the next cycle
    `RAAC_ASSERT_NEXT(a_append_rsp, clk, rst_n, req_xfer && req_operation == OP_APPEND,
                      rsp_valid && (rsp_status == ST_OK || rsp_status == ST_TABLE_FULL))
    // attributes only travel with an ok status
    `RAAC_ASSERT_NOW(a_attr_zero, clk, rst_n, rsp_valid && rsp_status != ST_OK,
                     rsp_attributes == '0)
endmodule

bind region_access_attribute_check raac_checker u_raac_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (request.valid),
    .req_ready      (request.ready),
    .req_operation  (request.operation),
    .rsp_valid      (response.valid),
    .rsp_ready      (response.ready),
    .rsp_status     (response.status),
    .rsp_attributes (response.attributes)
);

FILE: tb/testbench.sv
// self-checking testbench for the region access attribute checker
module testbench;
    import raac_pkg::*;

    localparam int MAP_DEPTH     = DEFAULT_MAX_ENTRIES;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 2 * MAP_DEPTH + 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 10;

    // the fourth operation code has no function in the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one request as queued for the driver, with its own pacing
    typedef struct {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        logic [FLAG_W-1:0] flags;    // bit0 exec, bit1 write, bit2 read
        int unsigned       gap;      // idle cycles before it is offered
        bit                drain;    // wait for every response before offering
        bit                hold;     // receiver backs off once this one is taken
    } region_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FLAG_W-1:0]   attributes;
    } region_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    raac_req_if request_ch ();
    raac_rsp_if response_ch ();

    region_access_attribute_check #(
        .MAX_ENTRIES (MAP_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always #6 clk = ~clk;

    // stimulus and expectations
    region_op_t     pending_ops [$];
    region_result_t expected_results [$];
    int             outstanding = 0;     // responses still owed, updated once per edge
    bit             sender_calm = 1'b0;  // no gaps for items queued while set
    bit             mark_drain = 1'b0;
    bit             mark_hold = 1'b0;
    bit             hold_mark = 1'b0;    // the offered item triggers the long back-off

    // shadow copy of the region table
    logic [ADDR_W-1:0] map_start [MAP_DEPTH];
    logic [ADDR_W-1:0] map_len [MAP_DEPTH];
    logic [FLAG_W-1:0] map_flags [MAP_DEPTH];
    int                map_count = 0;

    int mismatch_count = 0;
    int op_seen [4] = '{default: 0};
    int status_seen [8] = '{default: 0};
    int cycle_count = 0;

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void report_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endfunction

    // walk the table from the first entry, the way a query does
    function automatic region_result_t scan_region_map(input logic [ADDR_W-1:0] q_start,
                                                       input logic [ADDR_W-1:0] q_len);
        region_result_t    res;
        logic [ADDR_W-1:0] q_end;
        logic [ADDR_W-1:0] cur;
        logic [ADDR_W-1:0] e_start;
        logic [ADDR_W-1:0] e_end;
        logic [FLAG_W-1:0] attr;
        logic [FLAG_W-1:0] first_attr;
        bit                found;

        res.status = ST_INVALID;
        res.attributes = '0;
        first_attr = '0;
        found = 1'b0;
        cur = q_start;
        if (map_count == 0 || q_len == '0)
            return res;
        q_end = q_start + (q_len - 64'd1);
        // range end past the top of the address space
        if (q_end < q_start)
            return res;
        for (int i = 0; i < map_count; i++)
        begin
            e_start = map_start[i];
            // zero length counts as the size of the whole address space
            e_end = e_start + (map_len[i] - 64'd1);
            if (e_end < e_start)
            begin
                res.status = ST_ABORTED;
                return res;
            end
            // inclusive-end overlap with the part of the range not yet covered
            if (!(q_end < cur) && ((cur <= e_start && q_end >= e_start) ||
                                   (e_start <= cur && e_end >= cur)))
            begin
                attr = ~map_flags[i];
                if (!found)
                begin
                    first_attr = attr;
                    found = 1'b1;
                end
                else if (attr != first_attr)
                begin
                    res.status = ST_INCONSISTENT;
                    return res;
                end
                cur = e_end + 64'd1;
            end
            if (e_end >= q_end)
                break;
        end
        if (!found)
        begin
            res.status = ST_NOT_FOUND;
            return res;
        end
        res.status = ST_OK;
        res.attributes = first_attr;
        return res;
    endfunction

    // apply one accepted request to the shadow table and give its response
    function automatic region_result_t apply_to_region_map(input logic [1:0] op,
                                                           input logic [ADDR_W-1:0] addr,
                                                           input logic [ADDR_W-1:0] len,
                                                           input logic [FLAG_W-1:0] flags);
        region_result_t res;

        res.status = ST_INVALID;
        res.attributes = '0;
        case (op)
            OP_CLEAR:
            begin
                map_count = 0;
                res.status = ST_OK;
            end
            OP_APPEND:
            begin
                if (map_count >= MAP_DEPTH)
                    res.status = ST_TABLE_FULL;
                else
                begin
                    map_start[map_count] = addr;
                    map_len[map_count] = len;
                    map_flags[map_count] = flags;
                    map_count++;
                    res.status = ST_OK;
                end
            end
            OP_QUERY: res = scan_region_map(addr, len);
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_op(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [ADDR_W-1:0] len, input logic [FLAG_W-1:0] flags);
        region_op_t item;

        item.op = op;
        item.addr = addr;
        item.len = len;
        item.flags = flags;
        item.gap = sender_calm ? 0 : $urandom_range(0, 15);
        item.drain = mark_drain;
        item.hold = mark_hold;
        mark_drain = 1'b0;
        mark_hold = 1'b0;
        pending_ops.push_back(item);
    endtask

    // request driver: offers the head of the pending queue after its gap
    int unsigned gap_count;

    always @(posedge clk or negedge rst_n)
    begin
        region_op_t nxt;

        if (!rst_n)
        begin
            request_ch.valid <= 1'b0;
            request_ch.operation <= OP_CLEAR;
            request_ch.address <= '0;
            request_ch.length <= '0;
            request_ch.is_executable <= 1'b0;
            request_ch.is_writable <= 1'b0;
            request_ch.is_readable <= 1'b0;
            hold_mark <= 1'b0;
            gap_count <= 0;
        end
        else if (!request_ch.valid || request_ch.ready)
        begin
            // nothing offered, or the offered item transfers at this edge
            if (pending_ops.size() == 0)
                request_ch.valid <= 1'b0;
            else if (gap_count < pending_ops[0].gap)
            begin
                gap_count <= gap_count + 1;
                request_ch.valid <= 1'b0;
            end
            else if (pending_ops[0].drain && (request_ch.valid || outstanding != 0))
                request_ch.valid <= 1'b0;
            else
            begin
                nxt = pending_ops.pop_front();
                request_ch.valid <= 1'b1;
                request_ch.operation <= nxt.op;
                request_ch.address <= nxt.addr;
                request_ch.length <= nxt.len;
                request_ch.is_executable <= nxt.flags[0];
                request_ch.is_writable <= nxt.flags[1];
                request_ch.is_readable <= nxt.flags[2];
                hold_mark <= nxt.hold;
                gap_count <= 0;
            end
        end
    end

    // response sink: random stall after each transfer, quiet stretches, one long back-off
    int  sink_wait;
    int  hold_left;
    int  rsp_taken;

    always @(posedge clk or negedge rst_n)
    begin
        int stall;

        if (!rst_n)
        begin
            response_ch.ready <= 1'b0;
            sink_wait <= 0;
            hold_left <= 0;
            rsp_taken <= 0;
        end
        else if (request_ch.valid && request_ch.ready && hold_mark)
        begin
            hold_left <= HOLD_CYCLES;
            response_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            response_ch.ready <= (hold_left == 1);
        end
        else if (response_ch.valid && response_ch.ready)
        begin
            rsp_taken <= rsp_taken + 1;
            // every fourth stretch of 128 responses runs without stalls
            stall = ((rsp_taken % 512) >= 384) ? 0 : $urandom_range(0, 15);
            sink_wait <= stall;
            response_ch.ready <= (stall == 0);
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            response_ch.ready <= (sink_wait == 1);
        end
        else
            response_ch.ready <= 1'b1;
    end

    // monitor: check the response transfer first, then predict the request transfer
    always @(posedge clk or negedge rst_n)
    begin
        region_result_t want;

        if (!rst_n)
            outstanding <= 0;
        else
        begin
            if (response_ch.valid && response_ch.ready)
            begin
                status_seen[response_ch.status]++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf({"unexpected response at cycle %0d: ",
                                               "status %0d attributes %0d"},
                                              cycle_count, response_ch.status,
                                              response_ch.attributes));
                else
                begin
                    want = expected_results.pop_front();
                    if (response_ch.status !== want.status ||
                        response_ch.attributes !== want.attributes)
                        report_mismatch($sformatf({"cycle %0d: status %0d attributes %0d, ",
                                                   "expected status %0d attributes %0d"},
                                                  cycle_count, response_ch.status,
                                                  response_ch.attributes, want.status,
                                                  want.attributes));
                end
            end
            if (request_ch.valid && request_ch.ready)
            begin
                op_seen[request_ch.operation]++;
                expected_results.push_back(apply_to_region_map(request_ch.operation,
                    request_ch.address, request_ch.length,
                    {request_ch.is_readable, request_ch.is_writable, request_ch.is_executable}));
            end
            outstanding <= expected_results.size();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still owed",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int                directed_count;
        int                n_regions;
        int                n_queries;
        int                kind;
        int                i;
        int                j;
        bit                hold_done;
        bit                well_formed;
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] q_lo;
        logic [ADDR_W-1:0] q_hi;
        logic [FLAG_W-1:0] flags;
        logic [1:0]        op;
        logic [ADDR_W-1:0] seq_start [$];
        logic [ADDR_W-1:0] seq_len [$];

        // known levels on every input until the driver and sink take over
        request_ch.valid = 1'b0;
        request_ch.operation = OP_CLEAR;
        request_ch.address = '0;
        request_ch.length = '0;
        request_ch.is_executable = 1'b0;
        request_ch.is_writable = 1'b0;
        request_ch.is_readable = 1'b0;
        response_ch.ready = 1'b0;
        hold_done = 1'b0;

        // directed part
        queue_op(OP_QUERY, 64'h0, 64'h1, 3'b000);              // empty table: invalid
        queue_op(OP_UNUSED, 64'h1234, 64'h10, 3'b111);         // unused code: invalid
        queue_op(OP_APPEND, 64'h1000, 64'h1000, 3'b111);
        queue_op(OP_APPEND, 64'h2000, 64'h1000, 3'b111);
        queue_op(OP_APPEND, 64'h3000, 64'h1, 3'b101);          // one-byte region
        queue_op(OP_APPEND, 64'h3001, 64'h0fff, 3'b010);
        queue_op(OP_QUERY, 64'h1000, 64'h2000, 3'b000);        // two entries, same attrs
        queue_op(OP_QUERY, 64'h2fff, 64'h2, 3'b000);           // attrs differ
        queue_op(OP_QUERY, 64'h3000, 64'h1, 3'b000);           // one-byte match
        queue_op(OP_QUERY, 64'h1800, 64'h0, 3'b000);           // zero length
        queue_op(OP_QUERY, '1, 64'h2, 3'b000);                 // range end wraps
        queue_op(OP_QUERY, '1, 64'h1, 3'b000);                 // top byte, nothing there
        queue_op(OP_QUERY, 64'h0, 64'h10, 3'b000);             // below the first entry
        queue_op(OP_APPEND, 64'hffff_ffff_ffff_fff0, 64'h20, 3'b000);  // entry end wraps
        queue_op(OP_QUERY, 64'h3800, 64'h10, 3'b000);          // stops before the bad entry
        queue_op(OP_QUERY, 64'h5000, 64'h10, 3'b000);          // scan hits it: aborted
        queue_op(OP_CLEAR, '1, '1, 3'b111);
        queue_op(OP_APPEND, 64'h0, 64'h0, 3'b000);             // whole address space
        queue_op(OP_QUERY, '1, 64'h1, 3'b000);
        queue_op(OP_QUERY, 64'h0, '1, 3'b000);
        // fill the table with one-byte regions, then one too many
        queue_op(OP_CLEAR, 64'h0, 64'h0, 3'b000);
        for (i = 0; i < MAP_DEPTH; i++)
            queue_op(OP_APPEND, 64'h8000_0000_0000_0000 + i, 64'h1, 3'b100);
        queue_op(OP_APPEND, 64'h9000_0000_0000_0000, 64'h1, 3'b111);
        queue_op(OP_QUERY, 64'h8000_0000_0000_0000, 64'(MAP_DEPTH), 3'b000);  // full scan
        queue_op(OP_QUERY, 64'h8000_0000_0000_0000 + MAP_DEPTH - 1, 64'h1, 3'b000);
        directed_count = pending_ops.size();

        // random part: mostly clear / ordered appends / targeted queries
        mark_drain = 1'b1;
        while (pending_ops.size() < directed_count + RANDOM_ITEMS)
        begin
            sender_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 11) == 0)
                mark_drain = 1'b1;
            well_formed = ($urandom_range(0, 9) < 7);
            if (!hold_done && pending_ops.size() > directed_count + 500)
            begin
                // sender keeps offering back to back while the receiver backs off
                well_formed = 1'b1;
                sender_calm = 1'b1;
            end
            if (well_formed)
            begin
                queue_op(OP_CLEAR, rand64(), rand64(), 3'($urandom_range(0, 7)));
                n_regions = ($urandom_range(0, 7) == 0) ? $urandom_range(48, MAP_DEPTH + 2)
                                                        : $urandom_range(1, 12);
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    cursor = rand64();
                else if (kind == 1)
                    cursor = '1 - (rand64() >> $urandom_range(40, 63));
                else
                    cursor = rand64() >> $urandom_range(1, 40);
                flags = 3'($urandom_range(0, 7));
                seq_start.delete();
                seq_len.delete();
                for (i = 0; i < n_regions; i++)
                begin
                    kind = $urandom_range(0, 63);
                    if (kind == 0)
                        size = '0;
                    else if (kind == 1)
                        size = rand64() >> $urandom_range(1, 4);
                    else if (kind < 10)
                        size = 64'h1;
                    else
                        size = 64'h1 + (rand64() >> $urandom_range(36, 63));
                    if ($urandom_range(0, 3) == 0)
                        flags = 3'($urandom_range(0, 7));
                    queue_op(OP_APPEND, cursor, size, flags);
                    if (i < MAP_DEPTH)
                    begin
                        seq_start.push_back(cursor);
                        seq_len.push_back(size);
                    end
                    // occasional hole between neighbors
                    cursor = cursor + size +
                             (($urandom_range(0, 5) == 0) ? (rand64() >> $urandom_range(40, 63))
                                                          : 64'h0);
                end
                n_queries = $urandom_range(2, 8);
                for (i = 0; i < n_queries; i++)
                begin
                    if (!hold_done && sender_calm && i == 0 &&
                        pending_ops.size() > directed_count + 500)
                    begin
                        mark_hold = 1'b1;
                        hold_done = 1'b1;
                    end
                    if ($urandom_range(0, 7) == 0)
                        queue_op(OP_QUERY, rand64(), rand64() >> $urandom_range(0, 63),
                                 3'($urandom_range(0, 7)));
                    else
                    begin
                        j = $urandom_range(0, seq_start.size() - 1);
                        kind = $urandom_range(j, seq_start.size() - 1);
                        q_lo = seq_start[j] +
                               ((seq_len[j] == '0) ? rand64() : rand64() % seq_len[j]);
                        q_hi = seq_start[kind] +
                               ((seq_len[kind] == '0) ? rand64() : rand64() % seq_len[kind]);
                        // stretch past the neighbors now and then
                        if ($urandom_range(0, 5) == 0)
                            q_lo = q_lo - $urandom_range(1, 16);
                        if ($urandom_range(0, 5) == 0)
                            q_hi = q_hi + $urandom_range(1, 16);
                        if (q_hi < q_lo)
                        begin
                            size = q_lo;
                            q_lo = q_hi;
                            q_hi = size;
                        end
                        queue_op(OP_QUERY, q_lo, q_hi - q_lo + 64'h1,
                                 3'($urandom_range(0, 7)));
                    end
                end
            end
            else
            begin
                // noise on top of whatever the table holds
                n_queries = $urandom_range(1, 8);
                for (i = 0; i < n_queries; i++)
                begin
                    kind = $urandom_range(0, 15);
                    if (kind == 0)
                        op = OP_CLEAR;
                    else if (kind == 1)
                        op = OP_UNUSED;
                    else if (kind < 9)
                        op = OP_APPEND;
                    else
                        op = OP_QUERY;
                    queue_op(op, rand64(), rand64() >> $urandom_range(0, 63),
                             3'($urandom_range(0, 7)));
                end
            end
        end
        // last phase ends with the sender waiting for every response
        mark_drain = 1'b1;
        queue_op(OP_QUERY, 64'h0, '1, 3'b000);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || request_ch.valid || outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_results.size()));

        $display("covered %0d transfers: %0d clears, %0d appends, %0d queries, %0d unused code",
                 op_seen[OP_CLEAR] + op_seen[OP_APPEND] + op_seen[OP_QUERY] + op_seen[OP_UNUSED],
                 op_seen[OP_CLEAR], op_seen[OP_APPEND], op_seen[OP_QUERY], op_seen[OP_UNUSED]);
        $display({"responses: ok %0d invalid %0d aborted %0d not_found %0d ",
                  "inconsistent %0d full %0d"},
                 status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_ABORTED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_INCONSISTENT],
                 status_seen[ST_TABLE_FULL]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/raac_pkg.sv
hdl/raac_req_if.sv
hdl/raac_rsp_if.sv
hdl/raac_region_mem.sv
hdl/raac_ctrl.sv
hdl/region_access_attribute_check.sv
hdl/raac_checker.sv
tb/testbench.sv
